// ===== rtl/core/eegdf_pkg.sv =====
// Shared types and constants for the biosignal packet deframer.
// Used by every module under rtl/core except eegdf_ram; depends on nothing.
package eegdf_pkg;

   localparam int MAX_BLOCKS = 8;
   localparam int HISTORY_DEPTH = 2048;
   localparam int HIST_AW = $clog2(HISTORY_DEPTH);
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [3:0] CSR_CHANNEL_COUNT = 4'd0;
   localparam logic [3:0] CSR_SERIAL_MODE = 4'd1;

   // Result kinds.
   localparam logic [1:0] KIND_MARK = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_LEAD_OFF = 2'd2;

   localparam logic [8:0] CHANNEL_COUNT_RESET = 9'd32;
   localparam logic [11:0] FILL_MAX = 12'd4095;

   // One classified request handed from the front part to the back part.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] index;
      logic [31:0] data;
      logic [3:0] count;
      logic last;
   } rec_type;

endpackage

// ===== rtl/core/eegdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module eegdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/eegdf_fifo.sv =====
// Short queue of classified requests between the front and back parts.
// Depends on eegdf_pkg.
module eegdf_fifo (
   input logic clock,
   input logic reset,
   input logic push,
   input eegdf_pkg::rec_type push_rec,
   input logic pop,
   output eegdf_pkg::rec_type head_rec,
   output logic not_empty,
   output logic full
);

   localparam int PW = $clog2(eegdf_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(eegdf_pkg::QUEUE_DEPTH + 1);

   eegdf_pkg::rec_type slot_ff [eegdf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CW'(eegdf_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;
   assign head_rec = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(eegdf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(eegdf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== rtl/core/eegdf_front.sv =====
// Front part: configuration, byte history, sequence search and packet framing.
// Classifies each received byte into at most one request. Depends on eegdf_pkg, eegdf_ram.
module eegdf_front (
   input logic clock,
   input logic reset,
   input logic accept,
   input logic [7:0] rx_byte,
   input logic csr_write,
   input logic [3:0] csr_index,
   input logic [8:0] csr_wdata,
   output logic rec_valid,
   output eegdf_pkg::rec_type rec
);

   localparam int AW = eegdf_pkg::HIST_AW;

   logic [8:0] chan_ff;
   logic serial_ff;
   logic locked_ff, locked_in;
   logic [31:0] last_seq_ff, last_seq_in;
   logic [10:0] pos_ff, pos_in;
   logic [7:0] r_ff, r_in;
   logic [2:0] blk_ff, blk_in;
   logic [11:0] fill_ff, fill_in;
   logic [AW-1:0] wr_ff;
   logic [31:0] recent_ff, recent_in;
   logic [31:0] old_ff, old_in;
   logic [7:0] hist_rdata;

   logic few_ch;
   logic [5:0] per;
   logic [3:0] nb;
   logic [7:0] blk_size;
   logic [10:0] plen, total, q;
   logic [11:0] fill_inc;
   logic [6:0] bits, bits8;
   logic [7:0] j;
   logic [3:0] cnt;
   logic [AW-1:0] rd_addr;

   // Packet geometry from the channel count.
   always_comb begin
      few_ch = (chan_ff < 9'd32);
      per = few_ch ? chan_ff[5:0] : 6'd32;
      if (few_ch) begin
         nb = 4'd1;
      end else if (chan_ff[8:5] > 4'(eegdf_pkg::MAX_BLOCKS)) begin
         nb = 4'(eegdf_pkg::MAX_BLOCKS);
      end else begin
         nb = chan_ff[8:5];
      end
      blk_size = {per, 2'b00} + 8'd8;
      plen = 11'd8 + 11'(nb) * 11'(blk_size);
      total = plen + 11'(serial_ff);
      q = plen + 11'd1;
   end

   // History ring: the byte q places back is fetched one request ahead.
   assign rd_addr = wr_ff - AW'(plen);

   eegdf_ram #(
      .WIDTH(8),
      .DEPTH(eegdf_pkg::HISTORY_DEPTH)
   ) u_hist (
      .clock(clock),
      .wr_en(accept),
      .wr_addr(wr_ff),
      .wr_data(rx_byte),
      .rd_en(accept),
      .rd_addr(rd_addr),
      .rd_data(hist_rdata)
   );

   assign recent_in = accept ? {rx_byte, recent_ff[31:8]} : recent_ff;
   assign old_in = accept ? {hist_rdata, old_ff[31:8]} : old_ff;
   assign fill_inc = (fill_ff < eegdf_pkg::FILL_MAX) ? fill_ff + 1'b1 : fill_ff;

   // Lead-off valid bit count below 32 channels.
   always_comb begin
      j = r_ff - {per, 2'b00};
      bits = {chan_ff[5:0], 1'b0};
      bits8 = {j[3:0], 3'b000};
      if (!few_ch) begin
         cnt = 4'd8;
      end else if (bits <= bits8) begin
         cnt = 4'd0;
      end else if (bits - bits8 >= 7'd8) begin
         cnt = 4'd8;
      end else begin
         cnt = 4'(bits - bits8);
      end
   end

   // Search, sequence check and framing for one request.
   always_comb begin
      locked_in = locked_ff;
      last_seq_in = last_seq_ff;
      pos_in = pos_ff;
      r_in = r_ff;
      blk_in = blk_ff;
      fill_in = fill_ff;
      rec_valid = 1'b0;
      rec = '0;
      if (accept) begin
         if (serial_ff && !locked_ff) begin
            r_in = '0;
            blk_in = '0;
            fill_in = fill_inc;
            if (fill_inc >= 12'(q) + 12'd4) begin
               if (old_in + 32'd1 == recent_in) begin
                  locked_in = 1'b1;
                  last_seq_in = recent_in;
                  pos_in = 11'd4;
                  fill_in = '0;
               end else begin
                  fill_in = 12'(q) + 12'd3;
               end
            end
         end else begin
            pos_in = (pos_ff + 11'd1 >= total) ? '0 : pos_ff + 11'd1;
            if (pos_ff >= 11'd8) begin
               if (r_ff + 8'd1 == blk_size) begin
                  r_in = '0;
                  blk_in = blk_ff + 3'd1;
               end else begin
                  r_in = r_ff + 8'd1;
               end
            end else begin
               r_in = '0;
               blk_in = '0;
            end
            if (serial_ff && pos_ff == 11'd3) begin
               if (last_seq_ff + 32'd1 != recent_in) begin
                  locked_in = 1'b0;
                  pos_in = '0;
                  fill_in = 12'd4;
               end else begin
                  last_seq_in = recent_in;
               end
            end else if (pos_ff == 11'd7) begin
               rec_valid = 1'b1;
               rec.kind = eegdf_pkg::KIND_MARK;
               rec.data = {24'd0, rx_byte};
            end else if (pos_ff >= 11'd8 && pos_ff < plen) begin
               if (r_ff < {per, 2'b00}) begin
                  if (r_ff[1:0] == 2'b11) begin
                     rec_valid = 1'b1;
                     rec.kind = eegdf_pkg::KIND_SAMPLE;
                     rec.index = {blk_ff, r_ff[6:2]};
                     rec.data = recent_in;
                  end
               end else begin
                  rec_valid = 1'b1;
                  rec.kind = eegdf_pkg::KIND_LEAD_OFF;
                  rec.index = {2'b00, blk_ff, j[2:0]};
                  rec.data = {24'd0, rx_byte};
                  rec.count = cnt;
                  rec.last = (pos_ff + 11'd1 == plen);
               end
            end
         end
      end
   end

   // Control state; a write to the channel-count or serial-mode register restarts framing.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= eegdf_pkg::CHANNEL_COUNT_RESET;
         serial_ff <= 1'b1;
         locked_ff <= 1'b0;
         last_seq_ff <= '0;
         pos_ff <= '0;
         r_ff <= '0;
         blk_ff <= '0;
         fill_ff <= '0;
         wr_ff <= '0;
         recent_ff <= '0;
      end else begin
         wr_ff <= accept ? wr_ff + 1'b1 : wr_ff;
         recent_ff <= recent_in;
         last_seq_ff <= last_seq_in;
         if (csr_write && (csr_index == eegdf_pkg::CSR_CHANNEL_COUNT ||
                           csr_index == eegdf_pkg::CSR_SERIAL_MODE)) begin
            if (csr_index == eegdf_pkg::CSR_CHANNEL_COUNT) begin
               chan_ff <= csr_wdata;
            end else begin
               serial_ff <= csr_wdata[0];
            end
            locked_ff <= 1'b0;
            pos_ff <= '0;
            r_ff <= '0;
            blk_ff <= '0;
            fill_ff <= '0;
         end else begin
            locked_ff <= locked_in;
            pos_ff <= pos_in;
            r_ff <= r_in;
            blk_ff <= blk_in;
            fill_ff <= fill_in;
         end
      end
   end

   // Window of the four bytes a packet length back.
   always_ff @(posedge clock) begin
      old_ff <= old_in;
   end

endmodule

// ===== rtl/core/eegdf_back.sv =====
// Back part: formats queued requests into results and holds the output register.
// Depends on eegdf_pkg.
module eegdf_back (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input eegdf_pkg::rec_type q_rec,
   output logic q_pop,
   input logic out_pop,
   output logic out_valid,
   output logic [1:0] item_type,
   output logic [7:0] channel_index,
   output logic signed [31:0] sample_value,
   output logic [7:0] mark_byte,
   output logic [7:0] lead_off_bits,
   output logic [3:0] lead_off_count,
   output logic last_of_packet
);

   logic valid_ff;
   logic [1:0] type_ff;
   logic [7:0] index_ff, mark_ff, bits_ff, mask;
   logic [31:0] sample_ff;
   logic [3:0] count_ff;
   logic last_ff;

   assign q_pop = q_valid && (!valid_ff || out_pop);
   assign mask = (q_rec.count >= 4'd8) ? 8'hFF : 8'((9'd1 << q_rec.count) - 9'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (out_pop) begin
         valid_ff <= 1'b0;
      end
   end

   // Result fields, zeroed where the kind does not use them.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         type_ff <= q_rec.kind;
         index_ff <= q_rec.index;
         sample_ff <= (q_rec.kind == eegdf_pkg::KIND_SAMPLE) ? q_rec.data : '0;
         mark_ff <= (q_rec.kind == eegdf_pkg::KIND_MARK) ? q_rec.data[7:0] : '0;
         bits_ff <= (q_rec.kind == eegdf_pkg::KIND_LEAD_OFF) ? (q_rec.data[7:0] & mask) : '0;
         count_ff <= q_rec.count;
         last_ff <= q_rec.last;
      end
   end

   assign out_valid = valid_ff;
   assign item_type = type_ff;
   assign channel_index = index_ff;
   assign sample_value = sample_ff;
   assign mark_byte = mark_ff;
   assign lead_off_bits = bits_ff;
   assign lead_off_count = count_ff;
   assign last_of_packet = last_ff;

endmodule

// ===== rtl/core/eeg_packet_deframer_unit.sv =====
// Top level of the packet deframer: front part, request queue and back part.
// A request that yields a result passes through the request queue and then the output register to the result ports.
// Throughput: one received byte per cycle while req_full is low, set by the single history read port.
// Reset: synchronous; restores the default registers, unlocks and empties the queue.
// History memory has no clearing pass; requests are accepted straight after reset.
// Depends on eegdf_pkg, eegdf_front, eegdf_fifo, eegdf_back.
module eeg_packet_deframer_unit (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [7:0] req_rx_byte,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic [1:0] rsp_item_type,
   output logic [7:0] rsp_channel_index,
   output logic signed [31:0] rsp_sample_value,
   output logic [7:0] rsp_mark_byte,
   output logic [7:0] rsp_lead_off_bits,
   output logic [3:0] rsp_lead_off_count,
   output logic rsp_last_of_packet,
   input logic csr_valid,
   output logic csr_ready,
   input logic [3:0] csr_index,
   input logic [8:0] csr_wdata
);

   logic accept, rec_valid, q_valid, q_pop, out_valid;
   eegdf_pkg::rec_type rec, q_rec;

   assign accept = req_push && !req_full;
   assign csr_ready = 1'b1;
   assign rsp_empty = !out_valid;

   eegdf_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rec_valid(rec_valid),
      .rec(rec)
   );

   eegdf_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(rec_valid),
      .push_rec(rec),
      .pop(q_pop),
      .head_rec(q_rec),
      .not_empty(q_valid),
      .full(req_full)
   );

   eegdf_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_rec(q_rec),
      .q_pop(q_pop),
      .out_pop(rsp_pop),
      .out_valid(out_valid),
      .item_type(rsp_item_type),
      .channel_index(rsp_channel_index),
      .sample_value(rsp_sample_value),
      .mark_byte(rsp_mark_byte),
      .lead_off_bits(rsp_lead_off_bits),
      .lead_off_count(rsp_lead_off_count),
      .last_of_packet(rsp_last_of_packet)
   );

   // Reset leaves both sides empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

   // Only lead-off results carry a bit count.
   a_count_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_item_type != eegdf_pkg::KIND_LEAD_OFF |-> rsp_lead_off_count == 4'd0)
      else $error("bit count on a non lead-off result");

   // The packet end is flagged on a lead-off result only.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_of_packet |-> rsp_item_type == eegdf_pkg::KIND_LEAD_OFF)
      else $error("packet end on a wrong result kind");

endmodule
